>>> rtl/lkcp_pkg.sv
// ----------------------------------------------------------------------------
// lkcp_pkg
// Shared types and constants of the LRU key cache policy block: command
// codes, sequencer states, register indexes and field widths.
// ----------------------------------------------------------------------------
package lkcp_pkg;

   // field widths
   localparam int KEY_W      = 31;
   localparam int CMD_W      = 3;
   localparam int CNT_OUT_W  = 9;
   localparam int BUDGET_W   = 40;
   localparam int BPE_W      = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 40;

   // parameter defaults
   localparam int DEPTH_DEFAULT    = 256;
   localparam int MIN_KEPT_DEFAULT = 20;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_BUDGET     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_ENTRY = 1'd1;

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD      = 3'd0,
      CMD_TOUCH    = 3'd1,
      CMD_CONTAINS = 3'd2,
      CMD_REMOVE   = 3'd3,
      CMD_CLEAR    = 3'd4,
      CMD_SMALLEST = 3'd5
   } cmd_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_RDLAST,
      ST_RDLAST_W,
      ST_SHIFT,
      ST_FRONT,
      ST_BUDGET,
      ST_EVRD,
      ST_EVRD_W,
      ST_COMPACT,
      ST_MIN,
      ST_DONE
   } state_type;

endpackage

>>> rtl/lru_key_cache_policy_top.sv
// ----------------------------------------------------------------------------
// lru_key_cache_policy_top
// Most-recently-used ordered key store with add, touch, contains, range
// remove, clear and smallest commands, plus byte-budget eviction.
// ----------------------------------------------------------------------------
// The keys live in one memory in recency order (slot 0 most recent). A small
// sequencer walks that memory one slot per cycle through a single read port,
// so the work per request grows with the number of stored keys: a lookup
// scan, a shift when a key moves to the front, budget evictions followed by a
// check and a read back of the last evicted key, a compaction pass for range
// remove, and a final scan for the smallest key, which every request ends
// with. The request side is stalled while a request is at work; one result
// register lets the next request start while the previous result still waits
// to be taken. The key memory needs no clearing pass after reset: only slots
// that hold a stored or just evicted key are ever read.
module lru_key_cache_policy_top
   import lkcp_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEFAULT,
   parameter int MIN_KEPT = MIN_KEPT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [KEY_W-1:0]      req_entry_key,
   input  logic [KEY_W-1:0]      req_range_end,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_hit,
   output logic [CNT_OUT_W-1:0]  rsp_evicted_count,
   output logic [KEY_W-1:0]      rsp_evicted_key,
   output logic [CNT_OUT_W-1:0]  rsp_entry_count,
   output logic                  rsp_smallest_valid,
   output logic [KEY_W-1:0]      rsp_smallest_key,
   // configuration port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PROD_W = (CNT_W + BPE_W > BUDGET_W) ? CNT_W + BPE_W : BUDGET_W;

   // key memory
   logic [KEY_W-1:0] mem [DEPTH];
   logic [KEY_W-1:0] rd_data_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [KEY_W-1:0] wr_data;

   // configuration registers
   logic [BUDGET_W-1:0] budget_ff;
   logic [BPE_W-1:0]    bpe_ff;

   // sequencer and datapath registers
   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] w_ff, w_in;
   logic [CNT_W-1:0] evicted_ff, evicted_in;
   logic             hit_ff, hit_in;
   logic             bev_ff, bev_in;
   logic [KEY_W-1:0] last_ev_ff, last_ev_in;
   logic [KEY_W-1:0] min_ff, min_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic [CNT_OUT_W-1:0] rsp_evc_ff, rsp_evc_in;
   logic [KEY_W-1:0]     rsp_evk_ff, rsp_evk_in;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic                 rsp_sv_ff, rsp_sv_in;
   logic [KEY_W-1:0]     rsp_sk_ff, rsp_sk_in;

   // shared scan signals
   logic                 req_take;
   logic                 rsp_load;
   logic                 issue;
   logic                 drained;
   logic                 match;
   logic                 in_range;
   logic                 over_budget;
   logic                 above_min;
   logic [CNT_W-1:0]     i_dec;
   logic [PROD_W-1:0]    prod;
   logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;
   logic [CNT_W+CNT_OUT_W-1:0] evc_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign i_dec    = i_ff - 1'b1;
   assign drained  = !issue && !pend_ff;
   assign match    = pend_ff && (rd_data_ff == key_ff);
   assign in_range = (rd_data_ff >= key_ff) && (rd_data_ff <= hi_ff);

   // budget check: charged size against the byte budget
   assign prod        = PROD_W'(count_ff) * PROD_W'(bpe_ff);
   assign over_budget = prod > PROD_W'(budget_ff);
   assign above_min   = count_ff > CNT_W'(MIN_KEPT);

   assign cnt_ext = {{CNT_OUT_W{1'b0}}, count_ff};
   assign evc_ext = {{CNT_OUT_W{1'b0}}, evicted_ff};

   // read issue per state
   always_comb begin
      issue   = 1'b0;
      rd_addr = i_ff[IDX_W-1:0];
      unique case (state_ff)
         ST_FIND, ST_COMPACT, ST_MIN: begin
            issue   = i_ff < count_ff;
            rd_addr = i_ff[IDX_W-1:0];
         end
         ST_SHIFT: begin
            issue   = i_ff != '0;
            rd_addr = i_dec[IDX_W-1:0];
         end
         ST_RDLAST: begin
            issue   = 1'b1;
            rd_addr = IDX_W'(DEPTH - 1);
         end
         ST_EVRD: begin
            issue   = 1'b1;
            rd_addr = count_ff[IDX_W-1:0];
         end
         default: begin
            issue   = 1'b0;
            rd_addr = i_ff[IDX_W-1:0];
         end
      endcase
   end
   assign rd_en = issue;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               priority case (req_command)
                  CMD_ADD, CMD_TOUCH, CMD_CONTAINS: state_in = ST_FIND;
                  CMD_REMOVE:                       state_in = ST_COMPACT;
                  default:                          state_in = ST_MIN;
               endcase
            end
         end
         ST_FIND: begin
            if (match) begin
               state_in = (cmd_ff == CMD_CONTAINS) ? ST_MIN : ST_SHIFT;
            end else if (drained) begin
               if (cmd_ff == CMD_ADD) begin
                  state_in = (count_ff == CNT_W'(DEPTH)) ? ST_RDLAST : ST_SHIFT;
               end else begin
                  state_in = ST_MIN;
               end
            end
         end
         ST_RDLAST:   state_in = ST_RDLAST_W;
         ST_RDLAST_W: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (drained) state_in = ST_FRONT;
         end
         ST_FRONT: begin
            if (cmd_ff == CMD_ADD && !hit_ff && budget_ff != '0) state_in = ST_BUDGET;
            else state_in = ST_MIN;
         end
         ST_BUDGET: begin
            if (!(over_budget && above_min)) state_in = bev_ff ? ST_EVRD : ST_MIN;
         end
         ST_EVRD:   state_in = ST_EVRD_W;
         ST_EVRD_W: state_in = ST_MIN;
         ST_COMPACT: begin
            if (drained) state_in = ST_MIN;
         end
         ST_MIN: begin
            if (drained) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory write control
   always_comb begin
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      hi_in      = hi_ff;
      count_in   = count_ff;
      i_in       = i_ff;
      w_in       = w_ff;
      evicted_in = evicted_ff;
      hit_in     = hit_ff;
      bev_in     = bev_ff;
      last_ev_in = last_ev_ff;
      min_in     = min_ff;
      pidx_in    = rd_addr;
      pend_in    = issue && (state_in == state_ff);
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in     = cmd_type'(req_command);
               key_in     = req_entry_key;
               hi_in      = req_range_end;
               i_in       = '0;
               w_in       = '0;
               evicted_in = '0;
               hit_in     = 1'b0;
               bev_in     = 1'b0;
               last_ev_in = '0;
               min_in     = '0;
               // clear empties the store at once
               if (req_command == CMD_CLEAR) begin
                  evicted_in = count_ff;
                  count_in   = '0;
               end
            end
         end
         ST_FIND: begin
            i_in = i_ff + CNT_W'(issue);
            if (match) begin
               hit_in = 1'b1;
               i_in   = (cmd_ff == CMD_CONTAINS) ? '0 : CNT_W'(pidx_ff);
            end else if (drained) begin
               i_in = (cmd_ff == CMD_ADD) ? count_ff : '0;
            end
         end
         ST_RDLAST_W: begin
            // full store: drop the least recently used key first
            last_ev_in = rd_data_ff;
            evicted_in = evicted_ff + 1'b1;
            count_in   = count_ff - 1'b1;
            i_in       = CNT_W'(DEPTH - 1);
         end
         ST_SHIFT: begin
            // move each key one slot toward the tail
            i_in = i_ff - CNT_W'(issue);
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = pidx_ff + 1'b1;
               wr_data = rd_data_ff;
            end
         end
         ST_FRONT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = key_ff;
            i_in    = '0;
            if (cmd_ff == CMD_ADD && !hit_ff) count_in = count_ff + 1'b1;
         end
         ST_BUDGET: begin
            if (over_budget && above_min) begin
               count_in   = count_ff - 1'b1;
               evicted_in = evicted_ff + 1'b1;
               bev_in     = 1'b1;
            end
         end
         ST_EVRD_W: begin
            last_ev_in = rd_data_ff;
            i_in       = '0;
         end
         ST_COMPACT: begin
            // keep keys outside the range, packed toward slot 0
            i_in = i_ff + CNT_W'(issue);
            if (pend_ff) begin
               if (in_range) begin
                  evicted_in = evicted_ff + 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = w_ff[IDX_W-1:0];
                  wr_data = rd_data_ff;
                  w_in    = w_ff + 1'b1;
               end
            end
            if (drained) begin
               count_in = w_ff;
               i_in     = '0;
            end
         end
         ST_MIN: begin
            i_in = i_ff + CNT_W'(issue);
            if (pend_ff && (pidx_ff == '0 || rd_data_ff < min_ff)) min_in = rd_data_ff;
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   // result register next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hit_in   = rsp_hit_ff;
      rsp_evc_in   = rsp_evc_ff;
      rsp_evk_in   = rsp_evk_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_sv_in    = rsp_sv_ff;
      rsp_sk_in    = rsp_sk_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_evc_in   = evc_ext[CNT_OUT_W-1:0];
         rsp_evk_in   = (cmd_ff == CMD_ADD && evicted_ff != '0) ? last_ev_ff : '0;
         rsp_cnt_in   = cnt_ext[CNT_OUT_W-1:0];
         rsp_sv_in    = count_ff != '0;
         rsp_sk_in    = min_ff;
      end
   end

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= '0;
         bpe_ff    <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BYTE_BUDGET:     budget_ff <= csr_wdata[BUDGET_W-1:0];
            CSR_BYTES_PER_ENTRY: bpe_ff    <= csr_wdata[BPE_W-1:0];
            default:             budget_ff <= budget_ff;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      key_ff     <= key_in;
      hi_ff      <= hi_in;
      i_ff       <= i_in;
      w_ff       <= w_in;
      evicted_ff <= evicted_in;
      hit_ff     <= hit_in;
      bev_ff     <= bev_in;
      last_ev_ff <= last_ev_in;
      min_ff     <= min_in;
      pidx_ff    <= pidx_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_evc_ff <= rsp_evc_in;
      rsp_evk_ff <= rsp_evk_in;
      rsp_cnt_ff <= rsp_cnt_in;
      rsp_sv_ff  <= rsp_sv_in;
      rsp_sk_ff  <= rsp_sk_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_evicted_count  = rsp_evc_ff;
   assign rsp_evicted_key    = rsp_evk_ff;
   assign rsp_entry_count    = rsp_cnt_ff;
   assign rsp_smallest_valid = rsp_sv_ff;
   assign rsp_smallest_key   = rsp_sk_ff;

endmodule
